[rtl/kpcc_pkg.sv]
// Shared types, constants and a helper function for the k-bit code coverage checker.
`timescale 1ns / 1ps
package kpcc_pkg;

  localparam int MAX_CODE_BITS_DEF = 16;
  localparam int LEN_W             = 5;
  localparam int COUNT_W           = 17;
  localparam int EPOCH_W           = 8;

  localparam logic [LEN_W-1:0]   LEN_RESET = 5'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_CLR = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_START = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  typedef struct packed {
    logic bit_in;
    logic new_string;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] distinct_count;
    logic               all_seen;
    logic               window_full;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic               new_string;
    logic               full;
    logic [LEN_W-1:0]   k;
    logic [EPOCH_W-1:0] tag;
  } probe_t;

  typedef struct packed {
    logic busy;
    logic epoch_at_last;
  } clr_status_t;

  // Lengths of zero map to one, lengths above the built maximum map to the maximum.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len,
                                               input logic [LEN_W-1:0] kmax);
    logic [LEN_W-1:0] res;
    if (len == '0) begin
      res = 5'd1;
    end else if (len > kmax) begin
      res = kmax;
    end else begin
      res = len;
    end
    return res;
  endfunction

endpackage

[rtl/kbit_pattern_coverage_checker.sv]
// Top level of the k-bit code coverage checker.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+----------------------------------
//   in      | receive   | in_valid / in_stall  | in_data (bit_in, new_string)
//   out     | send      | out_valid / out_stall| out_data (distinct_count, all_seen,
//           |           |                      |           window_full)
//   cfg     | receive   | cfg_we               | cfg_data (code_length)
//
// One item is accepted per cycle while in_stall is low; its result passes through the
// update stage register and the output queue before it can be taken.
// The seen-map read, tag compare and write back of one item use the single-port-write
// memory, with forwarding between consecutive items.
// After reset the seen-map is cleared, during which in_stall is high. Restarts use a new
// 8-bit epoch tag; when the tags run out (the 255th restart after reset, then every
// 254th) the restart is stalled while the seen-map is cleared again. A stalled output
// holds at most two results.
`timescale 1ns / 1ps
module kbit_pattern_coverage_checker import kpcc_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam logic [LEN_W-1:0] KMAX = LEN_W'(MAX_CODE_BITS);

  logic [LEN_W-1:0]         code_length;
  logic [LEN_W-1:0]         k;
  logic                     accept;
  logic                     pop;
  logic                     wrap_block;
  logic                     clr_req;
  logic                     room;
  logic [2:0]               fill_after;
  logic [1:0]               fill;
  logic [MAX_CODE_BITS-1:0] code;
  logic [MAX_CODE_BITS-1:0] clr_addr;
  probe_t                   probe;
  clr_status_t              status;
  logic                     s1_valid;
  logic                     mark_we;
  logic [MAX_CODE_BITS-1:0] mark_addr;
  logic [EPOCH_W-1:0]       mark_tag;
  out_item_t                result;
  logic                     mem_we;
  logic [MAX_CODE_BITS-1:0] mem_waddr;
  logic [EPOCH_W-1:0]       mem_wdata;
  logic [EPOCH_W-1:0]       rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= LEN_RESET;
    end else if (cfg_we) begin
      code_length <= cfg_data;
    end
  end

  assign k          = eff_len(code_length, KMAX);
  assign pop        = out_valid && !out_stall;
  assign fill_after = {1'b0, fill} + {2'b0, s1_valid} - {2'b0, pop};
  assign room       = (fill_after <= 3'd1);
  assign wrap_block = in_valid && in_data.new_string && status.epoch_at_last;
  assign clr_req    = wrap_block && !status.busy && !s1_valid;
  assign in_stall   = status.busy || wrap_block || !room;
  assign accept     = in_valid && !in_stall;

  assign mem_we    = status.busy || mark_we;
  assign mem_waddr = status.busy ? clr_addr : mark_addr;
  assign mem_wdata = status.busy ? EPOCH_CLR : mark_tag;

  kpcc_window #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_data  (in_data),
    .k        (k),
    .clr_req  (clr_req),
    .code     (code),
    .probe    (probe),
    .status   (status),
    .clr_addr (clr_addr)
  );

  kpcc_seen_mem #(
    .AW(MAX_CODE_BITS),
    .DW(EPOCH_W)
  ) u_seen_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (code),
    .rdata (rdata)
  );

  kpcc_update #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .probe     (probe),
    .code      (code),
    .rdata     (rdata),
    .s1_valid  (s1_valid),
    .mark_we   (mark_we),
    .mark_addr (mark_addr),
    .mark_tag  (mark_tag),
    .result    (result)
  );

  kpcc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (result),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .fill      (fill)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    !(status.busy && mark_we))
    else $error("Clearing pass and mark write collided.");

  assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2 && !pop) |-> !s1_valid)
    else $error("Output queue overflow.");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("Accepted item did not reach the update stage.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.all_seen) |-> out_data.window_full)
    else $error("All codes flagged before the window filled.");
`endif

endmodule

[rtl/kpcc_seen_mem.sv]
// Seen-map storage: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module kpcc_seen_mem #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/kpcc_window.sv]
// Window shift register, bit count, restart epoch and the seen-map clearing sequencer.
`timescale 1ns / 1ps
module kpcc_window import kpcc_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  in_item_t                 in_data,
  input  logic [LEN_W-1:0]         k,
  input  logic                     clr_req,
  output logic [MAX_CODE_BITS-1:0] code,
  output probe_t                   probe,
  output clr_status_t              status,
  output logic [MAX_CODE_BITS-1:0] clr_addr
);

  logic [MAX_CODE_BITS-1:0] window;
  logic [MAX_CODE_BITS-1:0] win_base;
  logic [MAX_CODE_BITS:0]   win_shift;
  logic [MAX_CODE_BITS-1:0] window_next;
  logic [MAX_CODE_BITS-1:0] code_mask;
  logic [LEN_W-1:0]         bits_received;
  logic [LEN_W-1:0]         bits_base;
  logic [LEN_W-1:0]         bits_received_next;
  logic [EPOCH_W-1:0]       epoch;
  logic [EPOCH_W-1:0]       epoch_next;
  logic                     busy;

  always_comb begin
    win_base           = in_data.new_string ? '0 : window;
    win_shift          = {win_base, in_data.bit_in};
    window_next        = win_shift[MAX_CODE_BITS-1:0];
    bits_base          = in_data.new_string ? '0 : bits_received;
    bits_received_next = (bits_base < k) ? bits_base + 5'd1 : bits_base;
    epoch_next         = in_data.new_string ? epoch + 8'd1 : epoch;
    code_mask          = ~({MAX_CODE_BITS{1'b1}} << k);
    code               = window_next & code_mask;
  end

  assign probe.valid      = accept;
  assign probe.new_string = in_data.new_string;
  assign probe.full       = (bits_received_next >= k);
  assign probe.k          = k;
  assign probe.tag        = epoch_next;

  assign status.busy          = busy;
  assign status.epoch_at_last = (epoch == EPOCH_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      bits_received <= '0;
      epoch         <= EPOCH_CLR;
      busy          <= 1'b1;
      clr_addr      <= '0;
    end else begin
      if (busy) begin
        clr_addr <= clr_addr + {{(MAX_CODE_BITS-1){1'b0}}, 1'b1};
        if (clr_addr == {MAX_CODE_BITS{1'b1}}) begin
          busy  <= 1'b0;
          epoch <= EPOCH_START;
        end
      end else if (clr_req) begin
        busy     <= 1'b1;
        clr_addr <= '0;
      end else if (accept) begin
        window        <= window_next;
        bits_received <= bits_received_next;
        epoch         <= epoch_next;
      end
    end
  end

endmodule

[rtl/kpcc_update.sv]
// Read-modify-write stage: tag compare with forwarding, mark write and distinct count.
`timescale 1ns / 1ps
module kpcc_update import kpcc_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  probe_t                   probe,
  input  logic [MAX_CODE_BITS-1:0] code,
  input  logic [EPOCH_W-1:0]       rdata,
  output logic                     s1_valid,
  output logic                     mark_we,
  output logic [MAX_CODE_BITS-1:0] mark_addr,
  output logic [EPOCH_W-1:0]       mark_tag,
  output out_item_t                result
);

  localparam int CW = MAX_CODE_BITS + 1;

  probe_t                   s1;
  logic [MAX_CODE_BITS-1:0] s1_code;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_base;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            target;
  logic [CW+COUNT_W-1:0]    count_wide;
  logic                     fwd_valid;
  logic [MAX_CODE_BITS-1:0] fwd_addr;
  logic [EPOCH_W-1:0]       fwd_tag;
  logic [EPOCH_W-1:0]       cur_tag;
  logic                     seen;

  always_comb begin
    cur_tag    = (fwd_valid && (fwd_addr == s1_code)) ? fwd_tag : rdata;
    seen       = (cur_tag == s1.tag);
    mark_we    = s1.valid && s1.full && !seen;
    count_base = s1.new_string ? '0 : count;
    count_next = count_base + {{(CW-1){1'b0}}, mark_we};
    target     = {{(CW-1){1'b0}}, 1'b1} << s1.k;
    count_wide = {{COUNT_W{1'b0}}, count_next};
  end

  assign s1_valid  = s1.valid;
  assign mark_addr = s1_code;
  assign mark_tag  = s1.tag;

  assign result.distinct_count = count_wide[COUNT_W-1:0];
  assign result.all_seen       = s1.full && (count_next == target);
  assign result.window_full    = s1.full;

  always_ff @(posedge clk) begin
    s1.new_string <= probe.new_string;
    s1.full       <= probe.full;
    s1.k          <= probe.k;
    s1.tag        <= probe.tag;
    if (rst) begin
      s1.valid  <= 1'b0;
      count     <= '0;
      fwd_valid <= 1'b0;
    end else begin
      s1.valid  <= probe.valid;
      fwd_valid <= mark_we;
      if (s1.valid) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_code  <= code;
    fwd_addr <= s1_code;
    fwd_tag  <= s1.tag;
  end

endmodule

[rtl/kpcc_out_buf.sv]
// Two-entry output queue that separates result delivery from the update stage.
`timescale 1ns / 1ps
module kpcc_out_buf import kpcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  input  logic      pop,
  output logic      out_valid,
  output out_item_t out_data,
  output logic [1:0] fill
);

  out_item_t slots [2];
  logic      rd_ptr;
  logic      wr_ptr;

  assign out_valid = (fill != 2'd0);
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[verif/kbit_pattern_coverage_checker_tb.sv]
// Self-checking testbench for the k-bit code coverage checker with a built-in predictor.
`timescale 1ns / 1ps
module kbit_pattern_coverage_checker_tb;
  import kpcc_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int IDLE_PCT       = 15;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 16;

  class code_coverage_predictor;
    bit [LEN_W-1:0]             code_length;
    bit [MAX_CODE_BITS_DEF-1:0] window_bits;
    bit [LEN_W-1:0]             bits_taken;
    bit [COUNT_W-1:0]           code_count;
    bit                         seen_codes[int];
    out_item_t                  expected_results[$];
    int                         mismatches;
    int                         restarts;
    int                         checked;
    int                         full_coverage;

    function new();
      code_length = LEN_RESET;
    endfunction

    function void set_length(input bit [LEN_W-1:0] len);
      code_length = len;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_bit(input in_item_t item);
      int        k;
      int        code;
      out_item_t want;
      if (code_length == '0) begin
        k = 1;
      end else if (code_length > MAX_CODE_BITS_DEF) begin
        k = MAX_CODE_BITS_DEF;
      end else begin
        k = int'(code_length);
      end
      if (item.new_string) begin
        window_bits = '0;
        bits_taken = '0;
        code_count = '0;
        seen_codes.delete();
        restarts++;
      end
      window_bits = {window_bits[MAX_CODE_BITS_DEF-2:0], item.bit_in};
      if (bits_taken < k) bits_taken++;
      want = '0;
      want.window_full = (bits_taken >= k);
      if (want.window_full) begin
        code = int'(window_bits) & ((1 << k) - 1);
        if (!seen_codes.exists(code)) begin
          seen_codes[code] = 1'b1;
          code_count++;
        end
      end
      want.distinct_count = code_count;
      want.all_seen = want.window_full && (int'(code_count) == (1 << k));
      if (want.all_seen) full_coverage++;
      expected_results.push_back(want);
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("tb: unexpected result: count %0d all_seen %0b window_full %0b",
                   got.distinct_count, got.all_seen, got.window_full);
        end
        return;
      end
      want = expected_results.pop_front();
      if (got.distinct_count !== want.distinct_count || got.all_seen !== want.all_seen ||
          got.window_full !== want.window_full) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("tb: mismatch on result %0d: expected count %0d all_seen %0b full %0b,",
                   checked, want.distinct_count, want.all_seen, want.window_full);
          $display("tb:   got count %0d all_seen %0b full %0b",
                   got.distinct_count, got.all_seen, got.window_full);
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [LEN_W-1:0] cfg_data  = '0;

  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  int hold_ticket = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int quiet_cycles = 0;
  int lengths_used = 0;

  bit [LEN_W-1:0] phase_len [NUM_PHASES] = '{5'd3, 5'd1, 5'd4, 5'd2, 5'd0, 5'd5, 5'd16, 5'd3,
                                             5'd17, 5'd4, 5'd1, 5'd6, 5'd31, 5'd2, 5'd3, 5'd8};

  code_coverage_predictor coverage = new();

  kbit_pattern_coverage_checker dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) coverage.note_bit(in_data);
    if (!rst && out_valid && !out_stall) coverage.check_result(out_data);
  end

  always @(posedge clk) begin
    if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_bit(input logic b, input logic restart);
    in_item_t item;
    item.bit_in = b;
    item.new_string = restart;
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (coverage.pending() != 0) @(posedge clk);
  endtask

  task automatic set_code_length(input bit [LEN_W-1:0] len);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    coverage.set_length(len);
    lengths_used++;
  endtask

  initial begin
    int count;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset length of one: both codes, then a restart.
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b1);
    // Length zero behaves as one and keeps the earlier marks.
    set_code_length(5'd0);
    send_bit(1'b0, 1'b0);
    // All four two-bit codes after a restart.
    set_code_length(5'd2);
    send_bit(1'b0, 1'b1);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    // Oversized length changed mid-string: window and count carry on.
    set_code_length(5'd31);
    repeat (15) send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_code_length(phase_len[p]);
      tx_idle_on <= !(p >= 4 && p <= 6) && p != 1;
      rx_idle_on <= !(p >= 4 && p <= 6);
      if (p == 1) hold_ticket <= hold_ticket + 1;
      count = $urandom_range(45, 25);
      for (int i = 0; i < count; i++) begin
        if (p == 8 && i == count / 2) drain_results();
        send_bit(1'($urandom_range(1)), (i == 0) ? ($urandom_range(2) != 0)
                                                 : ($urandom_range(99) < 3));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d bits checked over %0d length settings, %0d restarts,",
             coverage.checked, lengths_used, coverage.restarts);
    $display("tb: %0d results with every code seen", coverage.full_coverage);
    if (coverage.mismatches == 0 && coverage.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
